>>> design/automaton_trim_reachability_core_assert.svh
// Assertion macros for the automaton trim reachability core.
// Each macro checks one property on the rising clock edge, held off during reset.
`ifndef AUTOMATON_TRIM_REACHABILITY_CORE_ASSERT_SVH
`define AUTOMATON_TRIM_REACHABILITY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATR_CHECK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATR_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/atr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automaton trim reachability package
// Sizes, command and status codes, and the byte population count that the
// trim core uses.
// ----------------------------------------------------------------------------
package atr_pkg;

   // Graph sizes.
   localparam int MAX_STATES = 64;
   localparam int MAX_EDGES  = 256;

   // Field widths.
   localparam int STATE_W  = 6;
   localparam int NUM_W    = 7;
   localparam int MASK_W   = 64;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 2;

   // Edge store addressing: the fill count must also hold the full depth.
   localparam int EDGE_AW = $clog2(MAX_EDGES);
   localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
   localparam int EDGE_DW = 2 * STATE_W;

   // The population count walks the result mask one byte per cycle.
   localparam int BYTE_W      = 8;
   localparam int ONES_W      = 4;
   localparam int COUNT_STEPS = MASK_W / BYTE_W;
   localparam int STEP_W      = $clog2(COUNT_STEPS);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_TRIM     = 2'd1,
      CMD_CLEAR    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_STATES = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   // Number of set bits in one byte.
   function automatic logic [ONES_W-1:0] byte_ones(input logic [BYTE_W-1:0] b);
      logic [ONES_W-1:0] c;
      c = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         c = c + ONES_W'(b[i]);
      end
      return c;
   endfunction

endpackage

>>> design/automaton_trim_reachability_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automaton trim reachability core
// Collects the transition edges of a state machine in an edge memory and, on
// a trim command, reports the states that are reachable from state 0 and
// can reach the end state, as a mask, a count and a status code.
// ----------------------------------------------------------------------------
// Handshake for users: an add-edge or clear word leaves busy low, so edges may
// be loaded back to back. A trim word raises busy while the edge memory is
// swept: each pass reads every stored edge once through the single read port.
// Passes repeat until neither reachability mask grows; the count state then
// adds up the result bits byte by byte before busy falls. With num_states
// of zero the result follows in the next cycle without busy. The result
// appears for exactly one cycle with rsp_strobe high and must be captured
// then; the receiver cannot hold it off. num_states is to be written through
// csr_write_enable only while the block is idle; the block does not enforce it.
module automaton_trim_reachability_core (
   input  logic                          clock,
   input  logic                          reset,
   // Command word
   input  logic                          start,
   output logic                          busy,
   input  logic [atr_pkg::CMD_W-1:0]     req_cmd,
   input  logic [atr_pkg::STATE_W-1:0]   req_edge_source,
   input  logic [atr_pkg::STATE_W-1:0]   req_edge_target,
   // Result word
   output logic                          rsp_strobe,
   output logic [atr_pkg::MASK_W-1:0]    rsp_accessible_mask,
   output logic [atr_pkg::COUNT_W-1:0]   rsp_accessible_count,
   output logic [atr_pkg::STATUS_W-1:0]  rsp_status,
   // Configuration
   input  logic                          csr_write_enable,
   input  logic [atr_pkg::NUM_W-1:0]     csr_write_data
);

`include "automaton_trim_reachability_core_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_COUNT
   } state_type;

   // Registers and their next values.
   state_type                      state_ff, state_in;
   logic [atr_pkg::NUM_W-1:0]      num_states_ff, num_states_in;
   logic [atr_pkg::EDGE_CW-1:0]    edge_count_ff, edge_count_in;
   logic                           overflow_ff, overflow_in;
   logic                           range_err_ff, range_err_in;
   logic                           stale_ff, stale_in;
   logic                           changed_ff, changed_in;
   logic [atr_pkg::MASK_W-1:0]     fwd_mask_ff, fwd_mask_in;
   logic [atr_pkg::MASK_W-1:0]     bwd_mask_ff, bwd_mask_in;
   logic [atr_pkg::EDGE_CW-1:0]    sweep_idx_ff, sweep_idx_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [atr_pkg::STEP_W-1:0]     count_idx_ff, count_idx_in;
   logic [atr_pkg::COUNT_W-1:0]    ones_acc_ff, ones_acc_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [atr_pkg::MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [atr_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [atr_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // Edge memory and its registered read port.
   logic [atr_pkg::EDGE_DW-1:0]    edge_mem [atr_pkg::MAX_EDGES];
   logic [atr_pkg::EDGE_DW-1:0]    mem_rd_data_ff;
   logic                           mem_we;

   logic                           accept;
   atr_pkg::cmd_type               cmd;
   logic [atr_pkg::NUM_W-1:0]      n_eff;
   logic                           req_out_of_range;
   logic                           store_full;
   logic [atr_pkg::STATE_W-1:0]    rd_source;
   logic [atr_pkg::STATE_W-1:0]    rd_target;
   logic                           rd_out_of_range;
   logic [atr_pkg::MASK_W-1:0]     trim_mask;
   logic [atr_pkg::ONES_W-1:0]     byte_count;
   logic [atr_pkg::COUNT_W-1:0]    ones_total;
   logic [atr_pkg::STATE_W-1:0]    end_state;

   // Handshake and decoded request.
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign cmd    = atr_pkg::cmd_type'(req_cmd);

   // The state count saturates at the largest supported graph.
   assign n_eff = (num_states_ff > atr_pkg::NUM_W'(atr_pkg::MAX_STATES)) ?
                  atr_pkg::NUM_W'(atr_pkg::MAX_STATES) : num_states_ff;
   assign end_state = atr_pkg::STATE_W'(n_eff - atr_pkg::NUM_W'(1));

   assign req_out_of_range = ({1'b0, req_edge_source} >= n_eff) ||
                             ({1'b0, req_edge_target} >= n_eff);
   assign store_full = (edge_count_ff == atr_pkg::EDGE_CW'(atr_pkg::MAX_EDGES));
   assign mem_we = accept && (cmd == atr_pkg::CMD_ADD_EDGE) &&
                   !req_out_of_range && !store_full;

   // Fields of the edge word returned by the memory.
   assign rd_source       = mem_rd_data_ff[atr_pkg::EDGE_DW-1:atr_pkg::STATE_W];
   assign rd_target       = mem_rd_data_ff[atr_pkg::STATE_W-1:0];
   assign rd_out_of_range = ({1'b0, rd_source} >= n_eff) || ({1'b0, rd_target} >= n_eff);

   // Population count of the trimmed mask, one byte per cycle.
   assign trim_mask  = fwd_mask_ff & bwd_mask_ff;
   assign byte_count = atr_pkg::byte_ones(trim_mask[count_idx_ff * atr_pkg::BYTE_W +:
                                                    atr_pkg::BYTE_W]);
   assign ones_total = ones_acc_ff + atr_pkg::COUNT_W'(byte_count);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      num_states_in = num_states_ff;
      edge_count_in = edge_count_ff;
      overflow_in   = overflow_ff;
      range_err_in  = range_err_ff;
      stale_in      = stale_ff;
      changed_in    = changed_ff;
      fwd_mask_in   = fwd_mask_ff;
      bwd_mask_in   = bwd_mask_ff;
      sweep_idx_in  = sweep_idx_ff;
      rd_valid_in   = 1'b0;
      count_idx_in  = count_idx_ff;
      ones_acc_in   = ones_acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_mask_in   = rsp_mask_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write_enable) begin
         num_states_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  atr_pkg::CMD_ADD_EDGE: begin
                     if (req_out_of_range) begin
                        range_err_in = 1'b1;
                     end else if (store_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        edge_count_in = edge_count_ff + atr_pkg::EDGE_CW'(1);
                     end
                  end
                  atr_pkg::CMD_TRIM: begin
                     if (n_eff == '0) begin
                        // No states: answer at once and leave the masks empty.
                        fwd_mask_in   = '0;
                        bwd_mask_in   = '0;
                        rsp_strobe_in = 1'b1;
                        rsp_mask_in   = '0;
                        rsp_count_in  = '0;
                        rsp_status_in = atr_pkg::STATUS_NO_STATES;
                     end else begin
                        fwd_mask_in  = atr_pkg::MASK_W'(1);
                        bwd_mask_in  = atr_pkg::MASK_W'(1) << end_state;
                        stale_in     = 1'b0;
                        changed_in   = 1'b0;
                        sweep_idx_in = '0;
                        state_in     = S_SWEEP;
                     end
                  end
                  atr_pkg::CMD_CLEAR: begin
                     edge_count_in = '0;
                     overflow_in   = 1'b0;
                     range_err_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SWEEP: begin
            // Relax one edge a cycle against the current masks.
            if (rd_valid_ff) begin
               if (rd_out_of_range) begin
                  stale_in = 1'b1;
               end else begin
                  if (fwd_mask_ff[rd_source] && !fwd_mask_ff[rd_target]) begin
                     fwd_mask_in = fwd_mask_ff | (atr_pkg::MASK_W'(1) << rd_target);
                     changed_in  = 1'b1;
                  end
                  if (bwd_mask_ff[rd_target] && !bwd_mask_ff[rd_source]) begin
                     bwd_mask_in = bwd_mask_ff | (atr_pkg::MASK_W'(1) << rd_source);
                     changed_in  = 1'b1;
                  end
               end
            end

            // Issue the next read, or close the pass once the last word is in.
            if (sweep_idx_ff < edge_count_ff) begin
               sweep_idx_in = sweep_idx_ff + atr_pkg::EDGE_CW'(1);
               rd_valid_in  = 1'b1;
            end else if (!rd_valid_ff) begin
               if (changed_ff) begin
                  sweep_idx_in = '0;
                  changed_in   = 1'b0;
               end else begin
                  count_idx_in = '0;
                  ones_acc_in  = '0;
                  state_in     = S_COUNT;
               end
            end
         end

         S_COUNT: begin
            ones_acc_in = ones_total;
            if (count_idx_ff == atr_pkg::STEP_W'(atr_pkg::COUNT_STEPS - 1)) begin
               rsp_strobe_in = 1'b1;
               rsp_mask_in   = trim_mask;
               rsp_count_in  = ones_total;
               if (range_err_ff || stale_ff) begin
                  rsp_status_in = atr_pkg::STATUS_RANGE;
               end else if (overflow_ff) begin
                  rsp_status_in = atr_pkg::STATUS_OVERFLOW;
               end else begin
                  rsp_status_in = atr_pkg::STATUS_OK;
               end
               state_in = S_IDLE;
            end else begin
               count_idx_in = count_idx_ff + atr_pkg::STEP_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         num_states_ff <= '0;
         edge_count_ff <= '0;
         overflow_ff   <= 1'b0;
         range_err_ff  <= 1'b0;
         stale_ff      <= 1'b0;
         changed_ff    <= 1'b0;
         fwd_mask_ff   <= '0;
         bwd_mask_ff   <= '0;
         sweep_idx_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         count_idx_ff  <= '0;
         ones_acc_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_states_ff <= num_states_in;
         edge_count_ff <= edge_count_in;
         overflow_ff   <= overflow_in;
         range_err_ff  <= range_err_in;
         stale_ff      <= stale_in;
         changed_ff    <= changed_in;
         fwd_mask_ff   <= fwd_mask_in;
         bwd_mask_ff   <= bwd_mask_in;
         sweep_idx_ff  <= sweep_idx_in;
         rd_valid_ff   <= rd_valid_in;
         count_idx_ff  <= count_idx_in;
         ones_acc_ff   <= ones_acc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_mask_ff   <= rsp_mask_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Edge memory: written on an accepted edge, read at the sweep pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[edge_count_ff[atr_pkg::EDGE_AW-1:0]] <= {req_edge_source, req_edge_target};
      end
      mem_rd_data_ff <= edge_mem[sweep_idx_ff[atr_pkg::EDGE_AW-1:0]];
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_accessible_mask  = rsp_mask_ff;
   assign rsp_accessible_count = rsp_count_ff;
   assign rsp_status           = rsp_status_ff;

   // Checks on the sequencer.
   `ATR_CHECK_SAME(a_fill_bounded, clock, reset, 1'b1,
                   edge_count_ff <= atr_pkg::EDGE_CW'(atr_pkg::MAX_EDGES),
                   "edge fill count beyond capacity")
   `ATR_CHECK_SAME(a_sweep_in_fill, clock, reset, state_ff == S_SWEEP,
                   sweep_idx_ff <= edge_count_ff, "sweep pointer passed the fill count")
   `ATR_CHECK_NEXT(a_store_frozen, clock, reset, state_ff != S_IDLE,
                   $stable(edge_count_ff), "edge store changed during a trim")
   `ATR_CHECK_SAME(a_start_reached, clock, reset, state_ff != S_IDLE,
                   fwd_mask_ff[0], "start state missing from the forward mask")

endmodule
